/* hdl/polyline_mean_distance_simplify_unit_assert.svh */
// assertion macros shared by the simplifier rtl
`ifndef POLYLINE_MEAN_DISTANCE_SIMPLIFY_UNIT_ASSERT_SVH
`define POLYLINE_MEAN_DISTANCE_SIMPLIFY_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PMDS_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pmds same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define PMDS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pmds next-cycle check failed");

`endif

/* hdl/pmds_pkg.sv */
// shared types and constants of the polyline simplifier
`timescale 1ns / 1ps

package pmds_pkg;

	// field widths
	localparam int COORD_W = 24;
	localparam int LIMIT_W = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd200;

	// discard store
	localparam int DROP_DEPTH = 256;
	localparam int ADDR_W = $clog2(DROP_DEPTH);
	localparam int CNT_W = $clog2(DROP_DEPTH + 1);
	localparam logic [CNT_W-1:0] DROP_FULL = CNT_W'(DROP_DEPTH);

	// datapath widths
	localparam int DIFF_W = COORD_W + 1;
	localparam int MUL_W = DIFF_W + 1;
	localparam int PROD_W = 2 * MUL_W;
	localparam int CROSS_W = 2 * DIFF_W;
	localparam int DEN_W = 2 * DIFF_W;
	localparam int SPLIT_W = DIFF_W;
	localparam int HL_SHIFT = SPLIT_W + 1;
	localparam int HH_SHIFT = 2 * SPLIT_W;
	localparam int ACC_W = PROD_W + HH_SHIFT + 2;
	localparam int NUM_W = 2 * CROSS_W;
	localparam int ROOT_W = COORD_W + 2;
	localparam int QUO_W = 2 * ROOT_W;
	localparam int SREM_W = ROOT_W + 2;
	localparam int SUM_W = ROOT_W + CNT_W;
	localparam int THR_W = LIMIT_W + CNT_W;
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam int SQ_CNT_W = $clog2(ROOT_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);
	localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(ROOT_W - 1);

	// one 3d point, x in the low bits
	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	localparam int PT_W = $bits(point_t);

	// signed coordinate difference
	function automatic logic signed [DIFF_W-1:0] coord_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
	endfunction

endpackage

/* hdl/pmds_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module pmds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/polyline_mean_distance_simplify_unit.sv */
// top level of the mean-distance polyline simplifier
//
// channel   dir  payload                                   handshake
// cfg       in   cfg_wr_data = mean_error_limit            cfg_wr_en
// s_*       in   tdata = pos_x,pos_y,pos_z; tlast = seg end  tvalid/tready
// m_*       out  tdata = kept_x,y,z; tuser = closes,ovf;    tvalid/tready
//                tlast = run_last
//
// a point with no held point ahead of it needs no measurement, plus output waits.
// a point that decides a held point measures count + 1 points and may emit up to 2 results,
// count being the discard fill; a zero-length line uses the squared offset instead.
// each measured point runs the 100-step restoring divider (not on a zero-length line) and 26-step square root.
// arst_n clears anchor, held point and fill count; the store itself is not cleared.
// the output register lets the next point in while a result waits on m_tready.
`timescale 1ns / 1ps
`include "polyline_mean_distance_simplify_unit_assert.svh"

module polyline_mean_distance_simplify_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [pmds_pkg::LIMIT_W-1:0]    cfg_wr_data,  // mean_error_limit
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pmds_pkg::PT_W-1:0]       s_tdata,      // pos_x, pos_y, pos_z
	input  logic                            s_tlast,      // segment_end
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pmds_pkg::PT_W-1:0]       m_tdata,      // kept_x, kept_y, kept_z
	output logic [1:0]                      m_tuser,      // closes_segment, store_overflow
	output logic                            m_tlast       // run_last
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEN, ST_RD, ST_LD, ST_MUL, ST_PREP, ST_DIV, ST_SQRT,
		ST_ACC, ST_THR, ST_DECIDE, ST_EMIT0, ST_EMIT1
	} state_t;

	typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

	typedef enum logic [2:0] {SUB_P1, SUB_P2, SUB_HH, SUB_HL, SUB_LL} sub_t;

	state_t state_q;
	logic [pmds_pkg::LIMIT_W-1:0] limit_q;
	pmds_pkg::point_t anchor_q, held_q, p_q, r0_pt_q;
	logic anchor_valid_q, held_valid_q, end_q;
	logic r0_ovf_q, r0_last_q, need1_q;
	logic [pmds_pkg::CNT_W-1:0] cnt_q, pt_q;
	logic signed [pmds_pkg::DIFF_W-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
	logic [pmds_pkg::DEN_W-1:0] den_q;
	logic zero_q;
	axis_t comp_q;
	sub_t sub_q;
	logic ph_q;
	logic signed [pmds_pkg::PROD_W-1:0] prod_q;
	logic signed [pmds_pkg::CROSS_W-1:0] cr_q;
	logic signed [pmds_pkg::ACC_W-1:0] acc_q;
	logic [pmds_pkg::DEN_W-1:0] rem_q;
	logic [pmds_pkg::NUM_W-1:0] num_q;
	logic [pmds_pkg::QUO_W-1:0] quo_q;
	logic [pmds_pkg::DIV_CNT_W-1:0] div_it_q;
	logic [pmds_pkg::ROOT_W-1:0] root_q;
	logic [pmds_pkg::SREM_W-1:0] srem_q;
	logic [pmds_pkg::SQ_CNT_W-1:0] sq_it_q;
	logic [pmds_pkg::SUM_W-1:0] sum_q;
	logic [pmds_pkg::THR_W-1:0] thr_q;
	logic m_tvalid_q, m_tlast_q;
	logic [pmds_pkg::PT_W-1:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	pmds_pkg::point_t p_in, c_pt, ram_rdata;
	logic in_fire, out_free, out_load;
	logic signed [pmds_pkg::MUL_W-1:0] op_a, op_b, h_ext, l_ext;
	logic signed [pmds_pkg::PROD_W-1:0] prod_c;
	logic mul_last;
	logic [pmds_pkg::DEN_W:0] div_trial, div_diff;
	logic div_ge;
	logic [pmds_pkg::SREM_W+1:0] sq_in, sq_test, sq_diff;
	logic sq_ge;
	logic [pmds_pkg::CNT_W-1:0] cnt_inc, pt_rd;
	logic [pmds_pkg::THR_W-1:0] thr_c;
	logic keep_c, full_c;
	logic ram_wr_en, ram_rd_en;

	// handshake
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign out_load = ((state_q == ST_EMIT0) || (state_q == ST_EMIT1)) & out_free;
	assign p_in = pmds_pkg::point_t'(s_tdata);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	// cross product split into high and low halves for squaring
	assign h_ext = $signed({cr_q[pmds_pkg::CROSS_W-1], cr_q[pmds_pkg::CROSS_W-1 -: pmds_pkg::SPLIT_W]});
	assign l_ext = $signed({1'b0, cr_q[pmds_pkg::SPLIT_W-1:0]});

	// multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_DEN) begin
			case (comp_q)
				AX_X: begin op_a = {ux_q[pmds_pkg::DIFF_W-1], ux_q}; op_b = op_a; end
				AX_Y: begin op_a = {uy_q[pmds_pkg::DIFF_W-1], uy_q}; op_b = op_a; end
				default: begin op_a = {uz_q[pmds_pkg::DIFF_W-1], uz_q}; op_b = op_a; end
			endcase
		end else if (zero_q) begin
			case (comp_q)
				AX_X: begin op_a = {vx_q[pmds_pkg::DIFF_W-1], vx_q}; op_b = op_a; end
				AX_Y: begin op_a = {vy_q[pmds_pkg::DIFF_W-1], vy_q}; op_b = op_a; end
				default: begin op_a = {vz_q[pmds_pkg::DIFF_W-1], vz_q}; op_b = op_a; end
			endcase
		end else begin
			case (sub_q)
				SUB_P1: begin
					case (comp_q)
						AX_X: begin
							op_a = {vy_q[pmds_pkg::DIFF_W-1], vy_q};
							op_b = {uz_q[pmds_pkg::DIFF_W-1], uz_q};
						end
						AX_Y: begin
							op_a = {vz_q[pmds_pkg::DIFF_W-1], vz_q};
							op_b = {ux_q[pmds_pkg::DIFF_W-1], ux_q};
						end
						default: begin
							op_a = {vx_q[pmds_pkg::DIFF_W-1], vx_q};
							op_b = {uy_q[pmds_pkg::DIFF_W-1], uy_q};
						end
					endcase
				end
				SUB_P2: begin
					case (comp_q)
						AX_X: begin
							op_a = {vz_q[pmds_pkg::DIFF_W-1], vz_q};
							op_b = {uy_q[pmds_pkg::DIFF_W-1], uy_q};
						end
						AX_Y: begin
							op_a = {vx_q[pmds_pkg::DIFF_W-1], vx_q};
							op_b = {uz_q[pmds_pkg::DIFF_W-1], uz_q};
						end
						default: begin
							op_a = {vy_q[pmds_pkg::DIFF_W-1], vy_q};
							op_b = {ux_q[pmds_pkg::DIFF_W-1], ux_q};
						end
					endcase
				end
				SUB_HH: begin op_a = h_ext; op_b = h_ext; end
				SUB_HL: begin op_a = h_ext; op_b = l_ext; end
				SUB_LL: begin op_a = l_ext; op_b = l_ext; end
				default: begin op_a = '0; op_b = '0; end
			endcase
		end
	end

	assign prod_c = $signed({{(pmds_pkg::PROD_W-pmds_pkg::MUL_W){op_a[pmds_pkg::MUL_W-1]}}, op_a})
		* $signed({{(pmds_pkg::PROD_W-pmds_pkg::MUL_W){op_b[pmds_pkg::MUL_W-1]}}, op_b});

	assign mul_last = (state_q == ST_DEN || zero_q) ? (comp_q == AX_Z)
		: (comp_q == AX_Z && sub_q == SUB_LL);

	// restoring divider step
	assign div_trial = {rem_q, num_q[pmds_pkg::NUM_W-1]};
	assign div_ge = div_trial >= {1'b0, den_q};
	assign div_diff = div_trial - {1'b0, den_q};

	// square root step
	assign sq_in = {srem_q, quo_q[pmds_pkg::QUO_W-1 -: 2]};
	assign sq_test = {2'b00, root_q, 2'b01};
	assign sq_ge = sq_in >= sq_test;
	assign sq_diff = sq_in - sq_test;

	// threshold and decision
	assign cnt_inc = cnt_q + pmds_pkg::CNT_W'(1);
	assign thr_c = {{(pmds_pkg::THR_W-pmds_pkg::LIMIT_W){1'b0}}, limit_q}
		* {{(pmds_pkg::THR_W-pmds_pkg::CNT_W){1'b0}}, cnt_inc};
	assign keep_c = sum_q > {{(pmds_pkg::SUM_W-pmds_pkg::THR_W){1'b0}}, thr_q};
	assign full_c = (cnt_q == pmds_pkg::DROP_FULL);

	// discard store access
	assign pt_rd = pt_q - pmds_pkg::CNT_W'(1);
	assign ram_rd_en = (state_q == ST_RD);
	assign ram_wr_en = (state_q == ST_DECIDE) & ~keep_c & ~full_c;
	assign c_pt = (pt_q == '0) ? held_q : ram_rdata;

	pmds_ram #(
		.WIDTH(pmds_pkg::PT_W),
		.DEPTH(pmds_pkg::DROP_DEPTH)
	) u_drop_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (cnt_q[pmds_pkg::ADDR_W-1:0]),
		.wr_data (held_q),
		.rd_en   (ram_rd_en),
		.rd_addr (pt_rd[pmds_pkg::ADDR_W-1:0]),
		.rd_data (ram_rdata)
	);

	// sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= pmds_pkg::LIMIT_RST;
			anchor_q <= '0;
			held_q <= '0;
			p_q <= '0;
			r0_pt_q <= '0;
			anchor_valid_q <= 1'b0;
			held_valid_q <= 1'b0;
			end_q <= 1'b0;
			r0_ovf_q <= 1'b0;
			r0_last_q <= 1'b0;
			need1_q <= 1'b0;
			cnt_q <= '0;
			pt_q <= '0;
			ux_q <= '0; uy_q <= '0; uz_q <= '0;
			vx_q <= '0; vy_q <= '0; vz_q <= '0;
			den_q <= '0;
			zero_q <= 1'b0;
			comp_q <= AX_X;
			sub_q <= SUB_P1;
			ph_q <= 1'b0;
			prod_q <= '0;
			cr_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			div_it_q <= '0;
			root_q <= '0;
			srem_q <= '0;
			sq_it_q <= '0;
			sum_q <= '0;
			thr_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			// output valid: load from an emit state, clear once taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						p_q <= p_in;
						end_q <= s_tlast;
						if (!anchor_valid_q) begin
							// segment opens: emit the point itself
							r0_pt_q <= p_in;
							r0_ovf_q <= 1'b0;
							r0_last_q <= ~s_tlast;
							need1_q <= s_tlast;
							if (!s_tlast) begin
								anchor_q <= p_in;
								anchor_valid_q <= 1'b1;
								held_valid_q <= 1'b0;
								cnt_q <= '0;
							end
							state_q <= ST_EMIT0;
						end else if (held_valid_q) begin
							// decide the held point against the new line
							ux_q <= pmds_pkg::coord_diff(p_in.x, anchor_q.x);
							uy_q <= pmds_pkg::coord_diff(p_in.y, anchor_q.y);
							uz_q <= pmds_pkg::coord_diff(p_in.z, anchor_q.z);
							den_q <= '0;
							comp_q <= AX_X;
							ph_q <= 1'b0;
							state_q <= ST_DEN;
						end else if (s_tlast) begin
							anchor_valid_q <= 1'b0;
							cnt_q <= '0;
							state_q <= ST_EMIT1;
						end else begin
							held_q <= p_in;
							held_valid_q <= 1'b1;
						end
					end
				end
				ST_DEN: begin
					// squared line length
					if (!ph_q) begin
						prod_q <= prod_c;
						ph_q <= 1'b1;
					end else begin
						den_q <= den_q + prod_q[pmds_pkg::DEN_W-1:0];
						ph_q <= 1'b0;
						if (mul_last) begin
							pt_q <= '0;
							sum_q <= '0;
							state_q <= ST_RD;
						end else begin
							comp_q <= axis_t'(comp_q + 2'd1);
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					// offset of the measured point from the anchor
					vx_q <= pmds_pkg::coord_diff(c_pt.x, anchor_q.x);
					vy_q <= pmds_pkg::coord_diff(c_pt.y, anchor_q.y);
					vz_q <= pmds_pkg::coord_diff(c_pt.z, anchor_q.z);
					zero_q <= (den_q == '0);
					acc_q <= '0;
					comp_q <= AX_X;
					sub_q <= SUB_P1;
					ph_q <= 1'b0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// squared cross product, or squared offset on a zero-length line
					if (!ph_q) begin
						prod_q <= prod_c;
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (zero_q) begin
							acc_q <= acc_q + {{(pmds_pkg::ACC_W-pmds_pkg::PROD_W){prod_q[pmds_pkg::PROD_W-1]}}, prod_q};
						end else begin
							case (sub_q)
								SUB_P1: cr_q <= prod_q[pmds_pkg::CROSS_W-1:0];
								SUB_P2: cr_q <= cr_q - prod_q[pmds_pkg::CROSS_W-1:0];
								SUB_HH: acc_q <= acc_q + {{(pmds_pkg::ACC_W-pmds_pkg::PROD_W-pmds_pkg::HH_SHIFT){prod_q[pmds_pkg::PROD_W-1]}},
									prod_q, {pmds_pkg::HH_SHIFT{1'b0}}};
								SUB_HL: acc_q <= acc_q + {{(pmds_pkg::ACC_W-pmds_pkg::PROD_W-pmds_pkg::HL_SHIFT){prod_q[pmds_pkg::PROD_W-1]}},
									prod_q, {pmds_pkg::HL_SHIFT{1'b0}}};
								SUB_LL: acc_q <= acc_q + {{(pmds_pkg::ACC_W-pmds_pkg::PROD_W){prod_q[pmds_pkg::PROD_W-1]}}, prod_q};
								default: acc_q <= acc_q;
							endcase
						end
						if (mul_last) begin
							state_q <= ST_PREP;
						end else if (zero_q || sub_q == SUB_LL) begin
							comp_q <= axis_t'(comp_q + 2'd1);
							sub_q <= SUB_P1;
						end else begin
							sub_q <= sub_t'(sub_q + 3'd1);
						end
					end
				end
				ST_PREP: begin
					root_q <= '0;
					srem_q <= '0;
					sq_it_q <= '0;
					if (zero_q) begin
						quo_q <= acc_q[pmds_pkg::QUO_W-1:0];
						state_q <= ST_SQRT;
					end else begin
						num_q <= acc_q[pmds_pkg::NUM_W-1:0];
						rem_q <= '0;
						quo_q <= '0;
						div_it_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// one quotient bit per cycle
					rem_q <= div_ge ? div_diff[pmds_pkg::DEN_W-1:0] : div_trial[pmds_pkg::DEN_W-1:0];
					num_q <= {num_q[pmds_pkg::NUM_W-2:0], 1'b0};
					quo_q <= {quo_q[pmds_pkg::QUO_W-2:0], div_ge};
					div_it_q <= div_it_q + pmds_pkg::DIV_CNT_W'(1);
					if (div_it_q == pmds_pkg::DIV_LAST) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					// one root bit per cycle
					srem_q <= sq_ge ? sq_diff[pmds_pkg::SREM_W-1:0] : sq_in[pmds_pkg::SREM_W-1:0];
					root_q <= {root_q[pmds_pkg::ROOT_W-2:0], sq_ge};
					quo_q <= {quo_q[pmds_pkg::QUO_W-3:0], 2'b00};
					sq_it_q <= sq_it_q + pmds_pkg::SQ_CNT_W'(1);
					if (sq_it_q == pmds_pkg::SQ_LAST) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_q <= sum_q + {{(pmds_pkg::SUM_W-pmds_pkg::ROOT_W){1'b0}}, root_q};
					if (pt_q == cnt_q) begin
						state_q <= ST_THR;
					end else begin
						pt_q <= pt_q + pmds_pkg::CNT_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_THR: begin
					thr_q <= thr_c;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					// keep or drop the held point, then take the new point
					if (keep_c || full_c) begin
						r0_pt_q <= held_q;
						r0_ovf_q <= ~keep_c;
						r0_last_q <= ~end_q;
						anchor_q <= held_q;
					end
					if (keep_c || full_c || end_q) begin
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_inc;
					end
					need1_q <= end_q;
					held_valid_q <= ~end_q;
					if (end_q) begin
						anchor_valid_q <= 1'b0;
					end else begin
						held_q <= p_q;
					end
					if (keep_c || full_c) begin
						state_q <= ST_EMIT0;
					end else if (end_q) begin
						state_q <= ST_EMIT1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT0: begin
					if (out_free) begin
						m_tdata_q <= r0_pt_q;
						m_tuser_q <= {r0_ovf_q, 1'b0};
						m_tlast_q <= r0_last_q;
						state_q <= need1_q ? ST_EMIT1 : ST_IDLE;
					end
				end
				ST_EMIT1: begin
					if (out_free) begin
						m_tdata_q <= p_q;
						m_tuser_q <= 2'b01;
						m_tlast_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	`PMDS_ASSERT_IMPL(a_fill_bound, 1'b1, cnt_q <= pmds_pkg::DROP_FULL)
	`PMDS_ASSERT_IMPL(a_held_needs_anchor, held_valid_q, anchor_valid_q)
	`PMDS_ASSERT_IMPL(a_ovf_not_closing, m_tvalid_q && m_tuser_q[1], !m_tuser_q[0])
	`PMDS_ASSERT_NEXT(a_decide_starts, in_fire && anchor_valid_q && held_valid_q, state_q == ST_DEN)

endmodule
